/* rtl/swle_pkg.sv */
// swle_pkg: shared types and constants of the sorted window loss estimator
// no dependencies; imported by the interfaces and all swle modules

package swle_pkg;

  // payload widths
  localparam int SEQ_W    = 16;
  localparam int SPAN_W   = 16;
  localparam int LOSS_W   = 20;

  // default window depth and fixed-point scale (100 percent in q8)
  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int Q8_SCALE         = 25600;

  // saturation bounds of the loss field
  localparam int LOSS_MIN = -524288;
  localparam int LOSS_MAX = 524287;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_FILLING   = 2'd0,
    STATUS_VALID     = 2'd1,
    STATUS_ZERO_SPAN = 2'd2
  } status_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_HOLD
  } state_e;

  // broadcast control to every window cell
  typedef struct packed {
    logic             load;
    logic             drop;
    logic [SEQ_W-1:0] ins;
  } cell_ctl_t;

endpackage

/* rtl/swle_if.sv */
// swle_seq_if / swle_res_if: valid/ready channels of the loss estimator
// depends on swle_pkg

interface swle_seq_if import swle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] sequence_number;

  modport source (output valid, output sequence_number, input ready);
  modport sink   (input valid, input sequence_number, output ready);
endinterface

interface swle_res_if import swle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_e                  status;
  logic signed [LOSS_W-1:0] loss_percent_q8;
  logic [SPAN_W-1:0]        span;

  modport source (output valid, output status, output loss_percent_q8, output span,
                  input ready);
  modport sink   (input valid, input status, input loss_percent_q8, input span,
                  output ready);
endinterface

/* rtl/swle_cell.sv */
// swle_cell: one entry of the sorted window, shifts with its neighbors
// depends on swle_pkg

module swle_cell import swle_pkg::*; (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic             occ_i,
  input  logic             tail_i,
  input  logic             first_i,
  input  logic [SEQ_W-1:0] left_w_i,
  input  logic             left_gt_i,
  input  logic [SEQ_W-1:0] right_w_i,
  input  logic             right_gt_i,
  output logic [SEQ_W-1:0] w_o,
  output logic             gt_o
);

  logic [SEQ_W-1:0] w_q, w_d;
  logic             gt;

  // stored entry is larger than the incoming number
  assign gt = occ_i && (w_q > ctl_i.ins);

  // next entry: plain insert, or drop smallest then insert
  always_comb begin
    w_d = w_q;
    if (ctl_i.drop) begin
      if (right_gt_i) begin
        w_d = (gt && !first_i) ? w_q : ctl_i.ins;
      end else begin
        w_d = right_w_i;
      end
    end else if (gt || tail_i) begin
      w_d = left_gt_i ? left_w_i : ctl_i.ins;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      w_q <= w_d;
    end
  end

  assign w_o  = w_q;
  assign gt_o = gt;

endmodule

/* rtl/swle_div.sv */
// swle_div: restoring divider of a constant dividend by the window span
// depends on swle_pkg

module swle_div import swle_pkg::*; #(
  parameter int DIVIDEND = Q8_SCALE * WINDOW_DEPTH_DEF,
  parameter int QW       = $clog2(DIVIDEND + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SPAN_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [QW-1:0]     quot_o,
  output logic              rem_nz_o
);

  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [SPAN_W-1:0] rem_q, rem_d;
  logic [SPAN_W-1:0] dvs_q;
  logic [QW-1:0]     quot_q, quot_d;
  logic              done_q, done_d;
  logic [SPAN_W:0]   trial;
  logic              ge;

  // one quotient bit per cycle, dividend bits shift out of the top
  assign trial = {rem_q, quot_q[QW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = CW'(QW);
      rem_d  = '0;
      quot_d = QW'(DIVIDEND);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      rem_d  = ge ? SPAN_W'(trial - {1'b0, dvs_q}) : SPAN_W'(trial);
      quot_d = {quot_q[QW-2:0], ge};
      done_d = (cnt_q == CW'(1));
    end
  end

  // control counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o   = cnt_q != '0;
  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = rem_q != '0;

endmodule

/* rtl/sorted_window_loss_estimator_top.sv */
// Sorted window packet loss estimator. Each transfer on in_i carries one
// sequence number; a row of WINDOW_DEPTH cells keeps the accepted numbers in
// ascending order and takes the insertion (dropping the smallest once full)
// in the cycle of the transfer. The next cycle reads span = max - min; with a
// full window and a nonzero span a restoring divider forms
// 25600*WINDOW_DEPTH/span, one quotient bit a cycle, and the loss is 25600
// minus that quotient, i.e. 25600*(span-WINDOW_DEPTH)/span. An item passes
// from the idle state through the calc state, the divider state only when
// the division runs, and the hold state. A finished result waits in an output
// register, so the next number is taken while it is still pending; numbers
// are taken only in the idle state. No clearing pass is needed after reset.
// depends on swle_pkg, swle_if, swle_cell, swle_div

module sorted_window_loss_estimator_top import swle_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swle_seq_if.sink   in_i,
  swle_res_if.source out_o
);

  localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int DIVIDEND = Q8_SCALE * WINDOW_DEPTH;
  localparam int XW       = $clog2(DIVIDEND + 1);
  localparam int LW       = XW + 2;
  localparam int SW       = (LW > LOSS_W) ? LW : LOSS_W;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SEQ_W-1:0]  max_q, max_d;
  logic [SPAN_W-1:0] span_q, span_calc;
  status_e           status_q, status_calc;
  logic              full, accept, in_ready, div_start, res_load, out_free;
  cell_ctl_t         ctl;

  logic [SEQ_W-1:0]        cw [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cgt;

  logic              div_busy, div_done, rem_nz;
  logic [XW-1:0]     quot;
  logic [XW:0]       qadj;
  logic signed [LW-1:0] loss_wide;
  logic signed [SW-1:0] loss_ext, loss_sat;
  logic signed [LOSS_W-1:0] loss_res;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic signed [LOSS_W-1:0] out_loss_q;
  logic [SPAN_W-1:0]        out_span_q;

  assign full     = cnt_q == CNT_W'(WINDOW_DEPTH);
  assign accept   = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;

  // fill count and running maximum
  always_comb begin
    cnt_d = cnt_q;
    max_d = max_q;
    if (accept) begin
      if (!full) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (cnt_q == '0 || in_i.sequence_number > max_q) begin
        max_d = in_i.sequence_number;
      end
    end
  end

  // broadcast to the cell row
  assign ctl.load = accept;
  assign ctl.drop = full;
  assign ctl.ins  = in_i.sequence_number;

  // row of window cells, each linked to its neighbors; the end cells see the input
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic [SEQ_W-1:0] left_w, right_w;
    logic             left_gt, right_gt;

    if (i == 0) begin : g_first
      assign left_w  = in_i.sequence_number;
      assign left_gt = 1'b0;
    end else begin : g_mid_l
      assign left_w  = cw[i-1];
      assign left_gt = cgt[i-1];
    end

    if (i == WINDOW_DEPTH - 1) begin : g_last
      assign right_w  = in_i.sequence_number;
      assign right_gt = 1'b1;
    end else begin : g_mid_r
      assign right_w  = cw[i+1];
      assign right_gt = cgt[i+1];
    end

    swle_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occ_i      (cnt_q > CNT_W'(i)),
      .tail_i     (cnt_q == CNT_W'(i)),
      .first_i    (i == 0),
      .left_w_i   (left_w),
      .left_gt_i  (left_gt),
      .right_w_i  (right_w),
      .right_gt_i (right_gt),
      .w_o        (cw[i]),
      .gt_o       (cgt[i])
    );
  end

  // span and status of the updated window
  assign span_calc = max_q - cw[0];

  always_comb begin
    if (!full) begin
      status_calc = STATUS_FILLING;
    end else if (span_calc == '0) begin
      status_calc = STATUS_ZERO_SPAN;
    end else begin
      status_calc = STATUS_VALID;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = (status_calc == STATUS_VALID) ? ST_DIV : ST_HOLD;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready  = 1'b1;
      ST_CALC: div_start = status_calc == STATUS_VALID;
      ST_HOLD: res_load  = out_free;
      default: ;
    endcase
  end

  swle_div #(
    .DIVIDEND (DIVIDEND),
    .QW       (XW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (span_calc),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_nz_o  (rem_nz)
  );

  // loss = 25600 - ceil or floor of dividend/span, truncated toward zero
  assign qadj      = {1'b0, quot}
                   + (XW + 1)'(rem_nz && (span_q >= SPAN_W'(WINDOW_DEPTH)));
  assign loss_wide = $signed(LW'(Q8_SCALE)) - $signed({1'b0, qadj});
  assign loss_ext  = SW'(loss_wide);

  always_comb begin
    if (loss_ext < $signed(SW'(LOSS_MIN))) begin
      loss_sat = SW'(LOSS_MIN);
    end else if (loss_ext > $signed(SW'(LOSS_MAX))) begin
      loss_sat = SW'(LOSS_MAX);
    end else begin
      loss_sat = loss_ext;
    end
  end

  assign loss_res = (status_q == STATUS_VALID) ? LOSS_W'(loss_sat) : '0;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    if (state_q == ST_CALC) begin
      span_q   <= span_calc;
      status_q <= status_calc;
    end
    if (res_load) begin
      out_status_q <= status_q;
      out_loss_q   <= loss_res;
      out_span_q   <= span_q;
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.loss_percent_q8 = out_loss_q;
  assign out_o.span            = out_span_q;

  // no new number is taken while a division is in flight
  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !div_busy)
    else $error("input transfer while divider busy");

  // a full window stays full after another transfer
  a_full_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full) |=> full)
    else $error("fill count left full window");

  // fill count never passes the window depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  // a valid estimate always has a nonzero span
  a_valid_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_VALID) |-> out_span_q != '0)
    else $error("valid estimate with zero span");

endmodule
